// ----- hdl/assert_macros.svh -----
// Assertion macros shared by the rate control RTL.
// Needs nothing else; include after the module ports are declared.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define ASSERT_IMPLIES(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error(msg);

// Invariant checked at every clock edge out of reset.
`define ASSERT_ALWAYS(lbl, clk, rstn, expr, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (expr)) \
        else $error(msg);

`endif

// ----- hdl/dcqcn_pkg.sv -----
// Shared types and constants for the DCQCN sender rate control block.
// No dependencies; used by dcqcn_sender_rate_control.
`timescale 1ns / 1ps
`default_nettype none

package dcqcn_pkg;

    localparam int COUNT_WIDTH_DEF = 48;
    localparam int ALPHA_FRAC_DEF  = 16;

    localparam int RATE_W     = 16;
    localparam int SEQ_W      = 48;
    localparam int ALPHA_W    = 17;
    localparam int INTV_W     = 24;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;
    // segment_size (16 bits) times 1000 (10 bits)
    localparam int INTV_DVD_W = 26;

    localparam logic [9:0]        KILO         = 10'd1000;
    localparam logic [INTV_W-1:0] INTERVAL_MAX = {INTV_W{1'b1}};

    localparam logic [CFG_DATA_W-1:0] ALPHA_GAIN_RST   = 16'd256;
    localparam logic [CFG_DATA_W-1:0] MIN_RATE_RST     = 16'd100;
    localparam logic [CFG_DATA_W-1:0] MAX_RATE_RST     = 16'd12500;
    localparam logic [CFG_DATA_W-1:0] START_RATE_RST   = 16'd12100;
    localparam logic [CFG_DATA_W-1:0] RATE_STEP_RST    = 16'd10;
    localparam logic [CFG_DATA_W-1:0] SEGMENT_SIZE_RST = 16'd1000;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_ALPHA_GAIN   = 3'd0,
        CFG_MIN_RATE     = 3'd1,
        CFG_MAX_RATE     = 3'd2,
        CFG_START_RATE   = 3'd3,
        CFG_RATE_STEP    = 3'd4,
        CFG_SEGMENT_SIZE = 3'd5
    } cfg_reg_t;

    typedef enum logic [2:0] {
        ACT_START      = 3'd0,
        ACT_ACK        = 3'd1,
        ACT_NACK       = 3'd2,
        ACT_ALPHA_TICK = 3'd3,
        ACT_INC_TICK   = 3'd4,
        ACT_SEND       = 3'd5
    } action_t;

    typedef struct packed {
        logic [2:0]       action;
        logic [SEQ_W-1:0] flow_bytes;
        logic [SEQ_W-1:0] ack_seq;
        logic             cnp;
    } in_item_t;

    typedef struct packed {
        logic               segment_valid;
        logic [RATE_W-1:0]  segment_bytes;
        logic [SEQ_W-1:0]   segment_end;
        logic               flow_done;
        logic               sending;
        logic               ack_overrun;
        logic [RATE_W-1:0]  current_rate;
        logic [ALPHA_W-1:0] alpha_now;
        logic [INTV_W-1:0]  send_interval;
    } out_item_t;

endpackage

`default_nettype wire

// ----- hdl/dcqcn_mul.sv -----
// Shared registered multiplier used by the rate control sequencer.
// Standalone; operand width is set by the top level.
`timescale 1ns / 1ps
`default_nettype none

module dcqcn_mul #(
    parameter int W = 26
) (
    input  wire logic           aclk,
    input  wire logic [W-1:0]   a,
    input  wire logic [W-1:0]   b,
    output logic      [2*W-1:0] p
);

    logic [2*W-1:0] p_reg;

    always_ff @(posedge aclk) begin
        p_reg <= (2*W)'(a) * (2*W)'(b);
    end

    assign p = p_reg;

endmodule

`default_nettype wire

// ----- hdl/dcqcn_div.sv -----
// Restoring divider, one quotient bit per cycle, for the send interval.
// Standalone; widths are set by the top level.
`timescale 1ns / 1ps
`default_nettype none

module dcqcn_div #(
    parameter int DVD_W = 26,
    parameter int DVS_W = 16
) (
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire logic             start,
    input  wire logic [DVD_W-1:0] dividend,
    input  wire logic [DVS_W-1:0] divisor,
    output logic                  done,
    output logic      [DVD_W-1:0] quotient
);

    localparam int CNT_W = $clog2(DVD_W + 1);

    logic [CNT_W-1:0] cnt_reg;
    logic             done_reg;
    logic [DVS_W-1:0] rem_reg;
    logic [DVD_W-1:0] quo_reg;
    logic [DVS_W-1:0] dvs_reg;

    logic [DVS_W:0] trial;
    logic [DVS_W:0] diff;
    logic           trial_ge;

    assign trial    = {rem_reg, quo_reg[DVD_W-1]};
    assign diff     = trial - {1'b0, dvs_reg};
    assign trial_ge = trial >= {1'b0, dvs_reg};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg  <= '0;
            done_reg <= 1'b0;
        end else begin
            done_reg <= (cnt_reg == CNT_W'(1)) && !start;
            if (start) begin
                cnt_reg <= CNT_W'(DVD_W);
            end else if (cnt_reg != '0) begin
                cnt_reg <= cnt_reg - CNT_W'(1);
            end
        end
    end

    // shift in the next dividend bit, subtract when it fits
    always_ff @(posedge aclk) begin
        if (start) begin
            rem_reg <= '0;
            quo_reg <= dividend;
            dvs_reg <= divisor;
        end else if (cnt_reg != '0) begin
            rem_reg <= trial_ge ? diff[DVS_W-1:0] : trial[DVS_W-1:0];
            quo_reg <= {quo_reg[DVD_W-2:0], trial_ge};
        end
    end

    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule

`default_nettype wire

// ----- hdl/dcqcn_sender_rate_control.sv -----
// DCQCN sender rate control: sequencer, state registers and result register.
// Depends on dcqcn_pkg, dcqcn_mul, dcqcn_div and assert_macros.svh.
//
// Usage: one event per request on the s_ channel (start flow, ack, nack,
// alpha tick, increase tick, send slot); one result per request on the m_
// channel. cfg_valid/cfg_index/cfg_data write the six tuning registers and
// are always taken; write them only while no request is in flight.
// Datapath: an event runs through a small sequencer that shares one
// registered multiplier for the alpha and rate updates and for
// segment_size*1000. The send interval comes from a 26-step restoring
// divider; a zero rate skips the divider. s_ready is high only between
// requests, so a new request is taken only after the previous result
// has been written to the output register.
// Reset (aresetn low, synchronous) clears the byte counters, loads alpha with
// one, the rate with the start-rate default and the tuning registers with theirs.
// Stall: the result sits in an output register; the next request may be
// accepted meanwhile, and its result waits until the previous one is taken.
`timescale 1ns / 1ps
`default_nettype none

module dcqcn_sender_rate_control #(
    parameter int COUNT_WIDTH     = dcqcn_pkg::COUNT_WIDTH_DEF,
    parameter int ALPHA_FRAC_BITS = dcqcn_pkg::ALPHA_FRAC_DEF
) (
    input  wire logic                                 aclk,
    input  wire logic                                 aresetn,
    input  wire logic                                 s_valid,
    output logic                                      s_ready,
    input  wire dcqcn_pkg::in_item_t                  s_data,
    output logic                                      m_valid,
    input  wire logic                                 m_ready,
    output dcqcn_pkg::out_item_t                      m_data,
    input  wire logic                                 cfg_valid,
    output logic                                      cfg_ready,
    input  wire logic [dcqcn_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  wire logic [dcqcn_pkg::CFG_DATA_W-1:0]     cfg_data
);

`include "assert_macros.svh"

    localparam int CW     = COUNT_WIDTH;
    localparam int F      = ALPHA_FRAC_BITS;
    localparam int AW     = F + 1;
    localparam int OPW    = (F + 2 > 16) ? F + 2 : 16;
    localparam int PW     = 2 * OPW;
    localparam int AW_EXT = (AW > dcqcn_pkg::ALPHA_W) ? AW : dcqcn_pkg::ALPHA_W;
    localparam int RW     = dcqcn_pkg::RATE_W;
    localparam int DVD_W  = dcqcn_pkg::INTV_DVD_W;

    localparam logic [AW-1:0]  ALPHA_ONE = AW'(1) << F;
    localparam logic [OPW-1:0] ONE_OP    = OPW'(1) << F;

    typedef enum logic [4:0] {
        ST_IDLE,
        ST_ACK_B,
        ST_ATICK_A,
        ST_ATICK_B,
        ST_INC,
        ST_CNG_A,
        ST_CNG_B,
        ST_CNG_C,
        ST_CNG_D,
        ST_SEG_A,
        ST_SEG_B,
        ST_INTV_A,
        ST_INTV_B,
        ST_DIV_WAIT,
        ST_FINISH
    } state_t;

    state_t state_reg, state_next;

    // tuning registers
    logic [RW-1:0] alpha_gain_reg, alpha_gain_next;
    logic [RW-1:0] min_rate_reg, min_rate_next;
    logic [RW-1:0] max_rate_reg, max_rate_next;
    logic [RW-1:0] start_rate_reg, start_rate_next;
    logic [RW-1:0] rate_step_reg, rate_step_next;
    logic [RW-1:0] seg_size_reg, seg_size_next;

    // flow state
    logic [CW-1:0] total_reg, total_next;
    logic [CW-1:0] sent_reg, sent_next;
    logic [CW-1:0] acked_reg, acked_next;
    logic [AW-1:0] alpha_reg, alpha_next;
    logic [RW-1:0] rate_reg, rate_next;
    logic [RW-1:0] target_reg, target_next;
    logic          inc_started_reg, inc_started_next;

    // per-request working registers
    logic [2:0]                    action_reg, action_next;
    logic                          cnp_reg, cnp_next;
    logic [CW-1:0]                 left_reg, left_next;
    logic                          avail_reg, avail_next;
    logic                          seg_valid_reg, seg_valid_next;
    logic [RW-1:0]                 seg_bytes_reg, seg_bytes_next;
    logic [dcqcn_pkg::SEQ_W-1:0]   seg_end_reg, seg_end_next;
    logic                          done_reg, done_next;
    logic                          overrun_reg, overrun_next;
    logic [dcqcn_pkg::INTV_W-1:0]  interval_reg, interval_next;

    logic                 m_valid_reg, m_valid_next;
    dcqcn_pkg::out_item_t m_data_reg, m_data_next;

    // datapath helpers
    logic [OPW-1:0]    gain_op;
    logic [OPW-1:0]    alpha_op;
    logic [OPW-1:0]    mul_a;
    logic [OPW-1:0]    mul_b;
    logic [PW-1:0]     mul_p;
    logic [RW-1:0]     cut_rate;
    logic [RW:0]       tgt_sum;
    logic [RW-1:0]     tgt_new;
    logic [RW:0]       rate_sum;
    logic [RW-1:0]     seg_n;
    logic [CW-1:0]     sent_plus;
    logic [CW-1:0]     seq_in;
    logic [AW_EXT-1:0] alpha_ext;
    logic              div_start;
    logic              div_done;
    logic [DVD_W-1:0]  div_quo;

    assign gain_op  = (OPW'(alpha_gain_reg) > ONE_OP) ? ONE_OP : OPW'(alpha_gain_reg);
    assign alpha_op = OPW'(alpha_reg);
    assign cut_rate = RW'(mul_p >> (F + 1));
    assign tgt_sum  = {1'b0, target_reg} + {1'b0, rate_step_reg};
    assign tgt_new  = !inc_started_reg ? target_reg :
                      (tgt_sum < {1'b0, max_rate_reg}) ? tgt_sum[RW-1:0] : max_rate_reg;
    assign rate_sum = {1'b0, tgt_new} + {1'b0, rate_reg};
    assign seg_n    = (left_reg < CW'(seg_size_reg)) ? left_reg[RW-1:0] : seg_size_reg;
    assign sent_plus = sent_reg + CW'(seg_n);
    assign seq_in   = CW'(s_data.ack_seq);
    assign alpha_ext = AW_EXT'(alpha_reg);

    // operand select for the shared multiplier
    always_comb begin
        unique case (state_reg)
            ST_ATICK_A, ST_CNG_A: begin
                mul_a = ONE_OP - gain_op;
                mul_b = alpha_op;
            end
            ST_CNG_C: begin
                mul_a = OPW'(rate_reg);
                mul_b = (ONE_OP << 1) - alpha_op;
            end
            ST_INTV_A: begin
                mul_a = OPW'(seg_size_reg);
                mul_b = OPW'(dcqcn_pkg::KILO);
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    dcqcn_mul #(
        .W(OPW)
    ) u_mul (
        .aclk (aclk),
        .a    (mul_a),
        .b    (mul_b),
        .p    (mul_p)
    );

    dcqcn_div #(
        .DVD_W(DVD_W),
        .DVS_W(RW)
    ) u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_start),
        .dividend (mul_p[DVD_W-1:0]),
        .divisor  (rate_reg),
        .done     (div_done),
        .quotient (div_quo)
    );

    always_comb begin
        state_next       = state_reg;
        alpha_gain_next  = alpha_gain_reg;
        min_rate_next    = min_rate_reg;
        max_rate_next    = max_rate_reg;
        start_rate_next  = start_rate_reg;
        rate_step_next   = rate_step_reg;
        seg_size_next    = seg_size_reg;
        total_next       = total_reg;
        sent_next        = sent_reg;
        acked_next       = acked_reg;
        alpha_next       = alpha_reg;
        rate_next        = rate_reg;
        target_next      = target_reg;
        inc_started_next = inc_started_reg;
        action_next      = action_reg;
        cnp_next         = cnp_reg;
        left_next        = left_reg;
        avail_next       = avail_reg;
        seg_valid_next   = seg_valid_reg;
        seg_bytes_next   = seg_bytes_reg;
        seg_end_next     = seg_end_reg;
        done_next        = done_reg;
        overrun_next     = overrun_reg;
        interval_next    = interval_reg;
        m_valid_next     = m_valid_reg;
        m_data_next      = m_data_reg;
        div_start        = 1'b0;

        if (cfg_valid) begin
            unique case (cfg_index)
                dcqcn_pkg::CFG_ALPHA_GAIN:   alpha_gain_next = cfg_data;
                dcqcn_pkg::CFG_MIN_RATE:     min_rate_next   = cfg_data;
                dcqcn_pkg::CFG_MAX_RATE:     max_rate_next   = cfg_data;
                dcqcn_pkg::CFG_START_RATE:   start_rate_next = cfg_data;
                dcqcn_pkg::CFG_RATE_STEP:    rate_step_next  = cfg_data;
                dcqcn_pkg::CFG_SEGMENT_SIZE: seg_size_next   = cfg_data;
                default: ;
            endcase
        end

        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end

        unique case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    action_next    = s_data.action;
                    cnp_next       = s_data.cnp;
                    seg_valid_next = 1'b0;
                    seg_bytes_next = '0;
                    seg_end_next   = '0;
                    done_next      = 1'b0;
                    overrun_next   = 1'b0;
                    unique case (s_data.action)
                        dcqcn_pkg::ACT_START: begin
                            total_next       = total_reg + CW'(s_data.flow_bytes);
                            alpha_next       = ALPHA_ONE;
                            inc_started_next = 1'b0;
                            rate_next        = start_rate_reg;
                            state_next       = ST_SEG_A;
                        end
                        dcqcn_pkg::ACT_ACK: begin
                            if (seq_in > acked_reg) begin
                                acked_next = seq_in;
                            end
                            state_next = ST_ACK_B;
                        end
                        dcqcn_pkg::ACT_NACK: begin
                            sent_next  = acked_reg;
                            state_next = s_data.cnp ? ST_CNG_A : ST_SEG_A;
                        end
                        dcqcn_pkg::ACT_ALPHA_TICK: begin
                            state_next = (total_reg != acked_reg) ? ST_ATICK_A : ST_INTV_A;
                        end
                        dcqcn_pkg::ACT_INC_TICK: begin
                            state_next = (total_reg != acked_reg) ? ST_INC : ST_INTV_A;
                        end
                        dcqcn_pkg::ACT_SEND: begin
                            state_next = ST_SEG_A;
                        end
                        default: begin
                            state_next = ST_INTV_A;
                        end
                    endcase
                end
            end
            ST_ACK_B: begin
                priority if (acked_reg > sent_reg) begin
                    sent_next    = acked_reg;
                    overrun_next = 1'b1;
                    state_next   = cnp_reg ? ST_CNG_A : ST_INTV_A;
                end else if (acked_reg == sent_reg) begin
                    // flow complete: drop any congestion mark
                    done_next  = 1'b1;
                    state_next = ST_INTV_A;
                end else begin
                    state_next = cnp_reg ? ST_CNG_A : ST_INTV_A;
                end
            end
            ST_ATICK_A: begin
                state_next = ST_ATICK_B;
            end
            ST_ATICK_B: begin
                alpha_next = AW'(mul_p >> F);
                state_next = ST_INTV_A;
            end
            ST_INC: begin
                target_next      = tgt_new;
                rate_next        = rate_sum[RW:1];
                inc_started_next = 1'b1;
                state_next       = ST_INTV_A;
            end
            ST_CNG_A: begin
                state_next = ST_CNG_B;
            end
            ST_CNG_B: begin
                alpha_next = AW'((mul_p + (PW'(gain_op) << F)) >> F);
                state_next = ST_CNG_C;
            end
            ST_CNG_C: begin
                target_next = rate_reg;
                state_next  = ST_CNG_D;
            end
            ST_CNG_D: begin
                rate_next        = (cut_rate < min_rate_reg) ? min_rate_reg : cut_rate;
                inc_started_next = 1'b0;
                state_next = (action_reg == dcqcn_pkg::ACT_NACK) ? ST_SEG_A : ST_INTV_A;
            end
            ST_SEG_A: begin
                left_next  = total_reg - sent_reg;
                avail_next = total_reg > sent_reg;
                state_next = ST_SEG_B;
            end
            ST_SEG_B: begin
                if (avail_reg) begin
                    sent_next      = sent_plus;
                    seg_valid_next = 1'b1;
                    seg_bytes_next = seg_n;
                    seg_end_next   = dcqcn_pkg::SEQ_W'(sent_plus);
                end
                state_next = ST_INTV_A;
            end
            ST_INTV_A: begin
                state_next = ST_INTV_B;
            end
            ST_INTV_B: begin
                if (rate_reg == '0) begin
                    interval_next = dcqcn_pkg::INTERVAL_MAX;
                    state_next    = ST_FINISH;
                end else begin
                    div_start  = 1'b1;
                    state_next = ST_DIV_WAIT;
                end
            end
            ST_DIV_WAIT: begin
                if (div_done) begin
                    interval_next = (div_quo > DVD_W'(dcqcn_pkg::INTERVAL_MAX)) ?
                                    dcqcn_pkg::INTERVAL_MAX :
                                    dcqcn_pkg::INTV_W'(div_quo);
                    state_next = ST_FINISH;
                end
            end
            ST_FINISH: begin
                // hold the result until the output register is free
                if (!m_valid_reg || m_ready) begin
                    m_data_next.segment_valid = seg_valid_reg;
                    m_data_next.segment_bytes = seg_bytes_reg;
                    m_data_next.segment_end   = seg_end_reg;
                    m_data_next.flow_done     = done_reg;
                    m_data_next.sending       = total_reg != acked_reg;
                    m_data_next.ack_overrun   = overrun_reg;
                    m_data_next.current_rate  = rate_reg;
                    m_data_next.alpha_now     = alpha_ext[dcqcn_pkg::ALPHA_W-1:0];
                    m_data_next.send_interval = interval_reg;
                    m_valid_next = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg       <= ST_IDLE;
            alpha_gain_reg  <= dcqcn_pkg::ALPHA_GAIN_RST;
            min_rate_reg    <= dcqcn_pkg::MIN_RATE_RST;
            max_rate_reg    <= dcqcn_pkg::MAX_RATE_RST;
            start_rate_reg  <= dcqcn_pkg::START_RATE_RST;
            rate_step_reg   <= dcqcn_pkg::RATE_STEP_RST;
            seg_size_reg    <= dcqcn_pkg::SEGMENT_SIZE_RST;
            total_reg       <= '0;
            sent_reg        <= '0;
            acked_reg       <= '0;
            alpha_reg       <= ALPHA_ONE;
            rate_reg        <= dcqcn_pkg::START_RATE_RST;
            target_reg      <= '0;
            inc_started_reg <= 1'b0;
            m_valid_reg     <= 1'b0;
        end else begin
            state_reg       <= state_next;
            alpha_gain_reg  <= alpha_gain_next;
            min_rate_reg    <= min_rate_next;
            max_rate_reg    <= max_rate_next;
            start_rate_reg  <= start_rate_next;
            rate_step_reg   <= rate_step_next;
            seg_size_reg    <= seg_size_next;
            total_reg       <= total_next;
            sent_reg        <= sent_next;
            acked_reg       <= acked_next;
            alpha_reg       <= alpha_next;
            rate_reg        <= rate_next;
            target_reg      <= target_next;
            inc_started_reg <= inc_started_next;
            m_valid_reg     <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        action_reg    <= action_next;
        cnp_reg       <= cnp_next;
        left_reg      <= left_next;
        avail_reg     <= avail_next;
        seg_valid_reg <= seg_valid_next;
        seg_bytes_reg <= seg_bytes_next;
        seg_end_reg   <= seg_end_next;
        done_reg      <= done_next;
        overrun_reg   <= overrun_next;
        interval_reg  <= interval_next;
        m_data_reg    <= m_data_next;
    end

    assign s_ready   = (state_reg == ST_IDLE);
    assign cfg_ready = 1'b1;
    assign m_valid   = m_valid_reg;
    assign m_data    = m_data_reg;

    `ASSERT_ALWAYS(a_alpha_bound, aclk, aresetn, alpha_reg <= ALPHA_ONE, "alpha above one")
    `ASSERT_NEXT(a_busy_after_accept, aclk, aresetn, s_valid && s_ready, !s_ready, "ready after accept")
    `ASSERT_IMPLIES(a_div_nonzero, aclk, aresetn, div_start, rate_reg != '0, "divide by zero rate")

endmodule

`default_nettype wire
